// File: rtl/fccm_pkg.sv
`timescale 1ns / 1ps

package fccm_pkg;

	localparam int DEF_MAX_FRAME_PIXELS = 65536;

	localparam int PIXEL_W = 8;
	localparam int CFG_W   = 17;
	localparam int OUT_W   = 18;
	localparam int FRAC_W  = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;
	localparam logic [OUT_W-1:0] Q_ONE     = 18'd65536;
	localparam logic [OUT_W-1:0] Q_TWO     = 18'd131072;

	// frame-end queue between accumulator and math unit
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic            empty;
		logic [Q_CW-1:0] used;
	} q_stat_t;

endpackage

// File: rtl/fccm_front.sv
`timescale 1ns / 1ps

module fccm_front import fccm_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
	localparam int AW = $clog2(MAX_FRAME_PIXELS),
	localparam int NW = AW + 1,
	localparam int SW = AW + PIXEL_W,
	localparam int QW = AW + 2 * PIXEL_W,
	localparam int EW = NW + 2 * SW + 3 * QW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIXEL_W-1:0] pixel,
	input  logic [CFG_W-1:0]   cfg_pixels,
	input  q_stat_t            q_stat,
	output logic               q_push,
	output logic [EW-1:0]      q_data
);

	localparam int CW = (CFG_W > NW) ? CFG_W : NW;

	logic [PIXEL_W-1:0] mem [MAX_FRAME_PIXELS];

	logic [AW-1:0]      idx_q;
	logic               first_q;
	logic [NW-1:0]      n_eff;
	logic [CW-1:0]      cfg_x;
	logic               last;
	logic               accept;
	logic [Q_CW:0]      busy;

	logic               v_s1, first_s1, last_s1, fwd_s1;
	logic [PIXEL_W-1:0] x_s1, fx_s1, rd_s1, y_s1;
	logic [AW-1:0]      idx_s1;
	logic [NW-1:0]      n_s1;

	logic                 v_s2, last_s2;
	logic [PIXEL_W-1:0]   x_s2, y_s2;
	logic [2*PIXEL_W-1:0] xx_s2, yy_s2, xy_s2;
	logic [NW-1:0]        n_s2;

	logic [SW-1:0] sx_q, sy_q, sx_n, sy_n;
	logic [QW-1:0] sxx_q, syy_q, sxy_q, sxx_n, syy_n, sxy_n;

	// effective frame size: zero acts as one, clamp to the store depth
	always_comb begin
		cfg_x = CW'(cfg_pixels);
		if (cfg_x == '0) begin
			n_eff = NW'(1);
		end else if (cfg_x > CW'(MAX_FRAME_PIXELS)) begin
			n_eff = NW'(MAX_FRAME_PIXELS);
		end else begin
			n_eff = NW'(cfg_x);
		end
	end

	assign last = ({1'b0, idx_q} + NW'(1)) >= n_eff;

	// reserve queue room for every frame end still in the pipe
	assign busy     = (Q_CW + 1)'(q_stat.used) + (Q_CW + 1)'(v_s1 & last_s1)
	                + (Q_CW + 1)'(v_s2 & last_s2);
	assign in_stall = busy >= (Q_CW + 1)'(Q_DEPTH);
	assign accept   = in_valid && !in_stall;

	// pixel store: read at accept, write in the cycle after
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[idx_q];
		end
		if (v_s1) begin
			mem[idx_s1] <= x_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= pixel;
			idx_s1   <= idx_q;
			first_s1 <= first_q;
			last_s1  <= last;
			n_s1     <= n_eff;
			fwd_s1   <= v_s1 && (idx_s1 == idx_q);
			fx_s1    <= x_s1;
		end
	end

	assign y_s1 = first_s1 ? x_s1 : (fwd_s1 ? fx_s1 : rd_s1);

	always_ff @(posedge clk) begin
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		xx_s2   <= x_s1 * x_s1;
		yy_s2   <= y_s1 * y_s1;
		xy_s2   <= x_s1 * y_s1;
		n_s2    <= n_s1;
		last_s2 <= last_s1;
	end

	assign sx_n  = sx_q + SW'(x_s2);
	assign sy_n  = sy_q + SW'(y_s2);
	assign sxx_n = sxx_q + QW'(xx_s2);
	assign syy_n = syy_q + QW'(yy_s2);
	assign sxy_n = sxy_q + QW'(xy_s2);

	assign q_push = v_s2 && last_s2;
	assign q_data = {n_s2, sx_n, sy_n, sxx_n, syy_n, sxy_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			first_q <= 1'b1;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				if (last) begin
					idx_q   <= '0;
					first_q <= 1'b0;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			if (v_s2) begin
				if (last_s2) begin
					sx_q  <= '0;
					sy_q  <= '0;
					sxx_q <= '0;
					syy_q <= '0;
					sxy_q <= '0;
				end else begin
					sx_q  <= sx_n;
					sy_q  <= sy_n;
					sxx_q <= sxx_n;
					syy_q <= syy_n;
					sxy_q <= sxy_n;
				end
			end
		end
	end

endmodule

// File: rtl/fccm_queue.sv
`timescale 1ns / 1ps

module fccm_queue import fccm_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output q_stat_t      stat
);

	logic [W-1:0]      ent_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q, rd_q;
	logic [Q_CW-1:0]   used_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	assign pop_data   = ent_q[rd_q];
	assign stat.used  = used_q;
	assign stat.empty = used_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			used_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			used_q <= used_q + Q_CW'(push) - Q_CW'(pop);
		end
	end

endmodule

// File: rtl/fccm_back.sv
`timescale 1ns / 1ps

module fccm_back import fccm_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
	localparam int AW = $clog2(MAX_FRAME_PIXELS),
	localparam int NW = AW + 1,
	localparam int SW = AW + PIXEL_W,
	localparam int QW = AW + 2 * PIXEL_W,
	localparam int EW = NW + 2 * SW + 3 * QW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_stat_t          q_stat,
	input  logic [EW-1:0]    q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] dissimilarity,
	output logic             degenerate
);

	localparam int OW  = QW;
	localparam int PW  = 2 * OW;
	localparam int SCW = $clog2(OW);
	localparam int QQW = FRAC_W + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_SQX  = 4'd3;
	localparam logic [3:0] S_SQY  = 4'd4;
	localparam logic [3:0] S_DEN  = 4'd5;
	localparam logic [3:0] S_DIV0 = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	localparam logic [2:0] K_LAST = 3'd6;

	logic [3:0]     state_q;
	logic [2:0]     k_q;
	logic [SCW-1:0] cnt_q;

	logic [OW-1:0]  n_q, sx_q, sy_q, sxx_q, syy_q, sxy_q;
	logic [OW-1:0]  opa, opb;
	logic [PW-1:0]  prod_q, vx_q, vy_q, pos_q, neg_q;

	logic [PW-1:0]  val_q;
	logic [OW+1:0]  rem_q, sq_r, sq_t;
	logic [OW-1:0]  root_q, root_n, rx_q;
	logic           sq_ge;

	logic           negf_q;
	logic [PW-1:0]  dr_q;
	logic [PW:0]    dv_r2;
	logic           dv_ge;
	logic [QQW-1:0] q_q;
	logic [OUT_W-1:0] q_pos, res_q;
	logic           degen_q;

	assign q_pop         = (state_q == S_IDLE) && !q_stat.empty;
	assign out_valid     = state_q == S_OUT;
	assign dissimilarity = res_q;
	assign degenerate    = degen_q;

	// shared multiplier operands
	always_comb begin
		opa = sx_q;
		opb = sy_q;
		if (state_q == S_DEN) begin
			opa = rx_q;
			opb = root_q;
		end else begin
			unique case (k_q)
				3'd0:    begin opa = n_q;  opb = sxx_q; end
				3'd1:    begin opa = sx_q; opb = sx_q;  end
				3'd2:    begin opa = n_q;  opb = syy_q; end
				3'd3:    begin opa = sy_q; opb = sy_q;  end
				3'd4:    begin opa = n_q;  opb = sxy_q; end
				default: begin opa = sx_q; opb = sy_q;  end
			endcase
		end
	end

	// one bit of the square root per cycle
	assign sq_r   = {rem_q[OW-1:0], val_q[PW-1:PW-2]};
	assign sq_t   = {root_q, 2'b01};
	assign sq_ge  = sq_r >= sq_t;
	assign root_n = {root_q[OW-2:0], sq_ge};

	// one quotient bit per cycle
	assign dv_r2  = {dr_q, 1'b0};
	assign dv_ge  = dv_r2 >= {1'b0, prod_q};

	assign q_pos  = OUT_W'(q_q) + Q_ONE;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sxy_q <= OW'(q_data[QW-1:0]);
			syy_q <= OW'(q_data[2*QW-1:QW]);
			sxx_q <= OW'(q_data[3*QW-1:2*QW]);
			sy_q  <= OW'(q_data[3*QW+SW-1:3*QW]);
			sx_q  <= OW'(q_data[3*QW+2*SW-1:3*QW+SW]);
			n_q   <= OW'(q_data[EW-1:3*QW+2*SW]);
		end
		unique case (state_q)
			S_MUL: begin
				if (k_q != K_LAST) begin
					prod_q <= opa * opb;
				end
				unique case (k_q)
					3'd1:    vx_q  <= prod_q;
					3'd2:    vx_q  <= vx_q - prod_q;
					3'd3:    vy_q  <= prod_q;
					3'd4:    vy_q  <= vy_q - prod_q;
					3'd5:    pos_q <= prod_q;
					3'd6:    neg_q <= prod_q;
					default: ;
				endcase
			end
			S_CHK: begin
				val_q  <= vx_q;
				rem_q  <= '0;
				root_q <= '0;
				if (vx_q == '0 || vy_q == '0) begin
					res_q   <= '0;
					degen_q <= 1'b1;
				end
			end
			S_SQX: begin
				if (cnt_q == SCW'(OW - 1)) begin
					rx_q   <= root_n;
					val_q  <= vy_q;
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					val_q  <= val_q << 2;
					rem_q  <= sq_ge ? sq_r - sq_t : sq_r;
					root_q <= root_n;
				end
			end
			S_SQY: begin
				val_q  <= val_q << 2;
				rem_q  <= sq_ge ? sq_r - sq_t : sq_r;
				root_q <= root_n;
			end
			S_DEN: begin
				prod_q <= opa * opb;
				negf_q <= pos_q < neg_q;
				pos_q  <= (pos_q >= neg_q) ? pos_q - neg_q : neg_q - pos_q;
			end
			S_DIV0: begin
				degen_q <= 1'b0;
				if ({1'b0, pos_q} >= {prod_q, 1'b0}) begin
					res_q <= negf_q ? Q_TWO : '0;
				end else if (pos_q >= prod_q) begin
					dr_q <= pos_q - prod_q;
					q_q  <= QQW'(1);
				end else begin
					dr_q <= pos_q;
					q_q  <= '0;
				end
			end
			S_DIV: begin
				dr_q <= dv_ge ? PW'(dv_r2 - {1'b0, prod_q}) : PW'(dv_r2);
				q_q  <= {q_q[QQW-2:0], dv_ge};
			end
			S_FIN: begin
				if (negf_q) begin
					res_q <= (q_pos > Q_TWO) ? Q_TWO : q_pos;
				end else begin
					res_q <= (OUT_W'(q_q) >= Q_ONE) ? '0 : Q_ONE - OUT_W'(q_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (q_pop) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == K_LAST) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					cnt_q   <= '0;
					state_q <= (vx_q == '0 || vy_q == '0) ? S_OUT : S_SQX;
				end
				S_SQX: begin
					if (cnt_q == SCW'(OW - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SQY;
					end else begin
						cnt_q <= cnt_q + SCW'(1);
					end
				end
				S_SQY: begin
					cnt_q <= cnt_q + SCW'(1);
					if (cnt_q == SCW'(OW - 1)) begin
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					state_q <= S_DIV0;
				end
				S_DIV0: begin
					cnt_q   <= '0;
					state_q <= ({1'b0, pos_q} >= {prod_q, 1'b0}) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + SCW'(1);
					if (cnt_q == SCW'(FRAC_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/frame_correlation_cut_metric.sv
`timescale 1ns / 1ps

// frame dissimilarity as one minus the pearson correlation of two frames
// input channel: in_valid / in_stall, one grayscale pixel per transaction,
//   raster order; a frame is frame_pixels transactions long
// output channel: out_valid / out_stall, one transaction per frame carrying
//   dissimilarity (unsigned Q2.16, 0..2) and the degenerate flag
// user writes frame_pixels (frame_pixels_we) only while idle; unenforced
// throughput: one pixel per cycle while in_stall is low; per frame the math
//   unit runs two 32-step square roots and a 16-step divide, skipped for a
//   zero-variance frame, so frames arriving faster than it finishes them
//   stall the input once the four-entry frame queue fills
// result path: stages s1, s2, the queue, then MUL, CHK, SQX, SQY, DEN,
//   DIV0, DIV, FIN, OUT; a zero-variance frame goes from CHK to OUT
// reset: first frame is compared with itself, sums and counters clear;
//   the pixel store is not cleared and needs no clearing pass
// a stalled output holds its transaction; the front keeps taking pixels
//   until the queue has no room left
module frame_correlation_cut_metric import fccm_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_pixels_we,
	input  logic [CFG_W-1:0]   frame_pixels,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIXEL_W-1:0] pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   dissimilarity,
	output logic               degenerate
);

	localparam int AW = $clog2(MAX_FRAME_PIXELS);
	localparam int NW = AW + 1;
	localparam int SW = AW + PIXEL_W;
	localparam int QW = AW + 2 * PIXEL_W;
	localparam int EW = NW + 2 * SW + 3 * QW;

	// frame size register
	logic [CFG_W-1:0] cfg_q;

	// frame-end sums moving from accumulator to math unit
	logic          q_push, q_pop;
	logic [EW-1:0] q_wdata, q_rdata;
	q_stat_t       q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (frame_pixels_we) begin
			cfg_q <= frame_pixels;
		end
	end

	// front: pixel store, previous-frame pixel lookup and running sums
	fccm_front #(
		.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.cfg_pixels(cfg_q),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// decouples frame ends from the slow math unit
	fccm_queue #(
		.W(EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.stat     (q_stat)
	);

	// back: variances, roots, divide and output register
	fccm_back #(
		.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dissimilarity(dissimilarity),
		.degenerate   (degenerate)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_stat.used < Q_CW'(Q_DEPTH)))
		else $error("frame queue overflow");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.used == Q_CW'(Q_DEPTH)) |-> in_stall)
		else $error("input open with full frame queue");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (dissimilarity == '0))
		else $error("degenerate result not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dissimilarity <= Q_TWO))
		else $error("dissimilarity out of range");
`endif

endmodule
